// ===== hw/rtl/vfm_pkg.sv =====
// Shared types, codes and constant tables of the voxel face-culling mesher.
`default_nettype none

package vfm_pkg;

  // Chunk geometry and the coordinate widths that follow from it
  localparam int CHUNK_EDGE   = 16;
  localparam int CHUNK_HEIGHT = 256;
  localparam int XZ_W         = $clog2(CHUNK_EDGE);
  localparam int Y_W          = $clog2(CHUNK_HEIGHT);
  localparam int PXZ_W        = $clog2(CHUNK_EDGE + 1);
  localparam int PY_W         = $clog2(CHUNK_HEIGHT + 1);

  localparam int NUM_FACES  = 6;
  localparam int VIDX_W     = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int QUEUE_DEPTH = 2;

  // Face numbers, also the normal direction
  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  localparam logic [7:0] ALPHA_WATER = 8'd200;
  localparam logic [7:0] ALPHA_SOLID = 8'd255;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AIR      = 3'd0,
    REG_WATER    = 3'd1,
    REG_GLASS    = 3'd2,
    REG_FILTER   = 3'd3,
    REG_FACE_SEL = 3'd4
  } reg_idx_t;

  // Face selection modes
  typedef enum logic [1:0] {
    FS_ALL    = 2'd0,
    FS_TOP    = 2'd1,
    FS_BOTTOM = 2'd2,
    FS_SIDES  = 2'd3
  } face_sel_t;

  // Base colour classes for the light scaling table
  localparam int NUM_BASE = 5;
  localparam logic [2:0] BASE_50  = 3'd0;
  localparam logic [2:0] BASE_100 = 3'd1;
  localparam logic [2:0] BASE_255 = 3'd2;
  localparam logic [2:0] BASE_200 = 3'd3;
  localparam logic [2:0] BASE_170 = 3'd4;
  localparam int unsigned BASE_VAL [NUM_BASE] = '{50, 100, 255, 200, 170};

  typedef logic [NUM_BASE-1:0][15:0][7:0] scale_tbl_t;

  // Build floor(c*(15+9L)/150) for every base colour and light level
  function automatic scale_tbl_t build_scale();
    scale_tbl_t  t;
    int unsigned c;
    for (int b = 0; b < NUM_BASE; b++) begin
      for (int l = 0; l < 16; l++) begin
        c = BASE_VAL[b];
        t[b][l] = 8'((c * (15 + 9 * l)) / 150);
      end
    end
    return t;
  endfunction

  localparam scale_tbl_t SCALE_TBL = build_scale();

  // Corner offsets per face: bit 2 x, bit 1 y, bit 0 z
  localparam logic [2:0] CORNER_TBL [NUM_FACES][4] = '{
    '{3'd5, 3'd4, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd3, 3'd2},
    '{3'd3, 3'd7, 3'd6, 3'd2},
    '{3'd0, 3'd4, 3'd5, 3'd1},
    '{3'd1, 3'd5, 3'd7, 3'd3},
    '{3'd4, 3'd0, 3'd2, 3'd6}
  };

  // Grey class of a solid block's face
  function automatic logic [2:0] grey_class(logic [2:0] f);
    case (f)
      FACE_PX, FACE_NX: grey_class = BASE_200;
      FACE_PY:          grey_class = BASE_255;
      FACE_NY:          grey_class = BASE_100;
      default:          grey_class = BASE_170;
    endcase
  endfunction

  // Input request: one block with its neighbours
  typedef struct packed {
    logic             first_of_chunk;
    logic [7:0]       block_type;
    logic [XZ_W-1:0]  block_x;
    logic [Y_W-1:0]   block_y;
    logic [XZ_W-1:0]  block_z;
    logic [47:0]      neighbor_types;
    logic [23:0]      neighbor_lights;
  } blk_t;

  // Output request: one vertex
  typedef struct packed {
    logic [VIDX_W-1:0] vert_idx;
    logic [PXZ_W-1:0]  pos_x;
    logic [PY_W-1:0]   pos_y;
    logic [PXZ_W-1:0]  pos_z;
    logic [2:0]        face;
    logic [1:0]        corner;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic              last;
  } vtx_t;

  // Classified block handed from front to back
  typedef struct packed {
    logic                       first;
    logic                       water;
    logic [NUM_FACES-1:0]       keep;
    logic [XZ_W-1:0]            bx;
    logic [Y_W-1:0]             by;
    logic [XZ_W-1:0]            bz;
    logic [NUM_FACES-1:0][3:0]  lights;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vfm_chan_if.sv =====
// Valid/ready channel interface carrying one request payload.
`default_nettype none

interface vfm_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vfm_front.sv =====
// Front end: configuration registers and per-block face classification.
`default_nettype none

module vfm_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [vfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vfm_pkg::CFG_DATA_W-1:0] cfg_data,
  vfm_chan_if.sink                            blk,
  input  wire vfm_pkg::q_stat_t               q_stat,
  output logic                                push,
  output vfm_pkg::job_t                       push_job
);

  logic [7:0]         air_code;
  logic [7:0]         water_code;
  logic [7:0]         glass_code;
  logic [8:0]         type_filter;
  vfm_pkg::face_sel_t face_select;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      air_code    <= 8'd0;
      water_code  <= 8'd1;
      glass_code  <= 8'd2;
      type_filter <= 9'h1FF;
      face_select <= vfm_pkg::FS_ALL;
    end else if (cfg_write) begin
      case (cfg_index)
        vfm_pkg::REG_AIR:      air_code    <= cfg_data[7:0];
        vfm_pkg::REG_WATER:    water_code  <= cfg_data[7:0];
        vfm_pkg::REG_GLASS:    glass_code  <= cfg_data[7:0];
        vfm_pkg::REG_FILTER:   type_filter <= cfg_data;
        vfm_pkg::REG_FACE_SEL: face_select <= vfm_pkg::face_sel_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  logic                          reject;
  logic                          is_water;
  logic [vfm_pkg::NUM_FACES-1:0] keep;
  logic [vfm_pkg::NUM_FACES-1:0] allowed;

  // Classify the block and each of its faces
  always_comb begin
    logic [7:0] nt;
    reject = (blk.data.block_type == air_code) ||
             (!type_filter[8] && (blk.data.block_type != type_filter[7:0]));
    is_water = (blk.data.block_type == water_code);
    case (face_select)
      vfm_pkg::FS_TOP:    allowed = 6'b000100;
      vfm_pkg::FS_BOTTOM: allowed = 6'b001000;
      vfm_pkg::FS_SIDES:  allowed = 6'b110011;
      default:            allowed = 6'b111111;
    endcase
    keep = '0;
    for (int f = 0; f < vfm_pkg::NUM_FACES; f++) begin
      nt = blk.data.neighbor_types[8*f +: 8];
      keep[f] = !reject && allowed[f] &&
                (nt == air_code || nt == water_code || nt == glass_code) &&
                !(is_water && nt == water_code);
    end
  end

  // Hand every accepted block to the queue; empty ones still carry first_of_chunk
  assign blk.ready = !q_stat.full;
  assign push      = blk.valid && !q_stat.full;

  always_comb begin
    push_job.first  = blk.data.first_of_chunk;
    push_job.water  = is_water;
    push_job.keep   = keep;
    push_job.bx     = blk.data.block_x;
    push_job.by     = blk.data.block_y;
    push_job.bz     = blk.data.block_z;
    push_job.lights = blk.data.neighbor_lights;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vfm_queue.sv =====
// Short job queue between the classifying front and the vertex back end.
`default_nettype none

module vfm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire vfm_pkg::job_t push_job,
  input  wire logic          pop,
  output vfm_pkg::job_t      head,
  output vfm_pkg::q_stat_t   stat
);

  localparam int PTR_W = (vfm_pkg::QUEUE_DEPTH > 1) ? $clog2(vfm_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(vfm_pkg::QUEUE_DEPTH + 1);

  vfm_pkg::job_t    entries [vfm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;

  logic do_push;
  logic do_pop;

  assign stat.full  = (cnt == CNT_W'(vfm_pkg::QUEUE_DEPTH));
  assign stat.empty = (cnt == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  // Store an entry on push
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(vfm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(vfm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vfm_back.sv =====
// Back end: walks the kept faces of a job and emits four vertices per face.
`default_nettype none

module vfm_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire vfm_pkg::q_stat_t q_stat,
  input  wire vfm_pkg::job_t    head,
  output logic                  pop,
  vfm_chan_if.source            vtx
);

  logic                          busy;
  vfm_pkg::job_t                 job;
  logic [vfm_pkg::NUM_FACES-1:0] remain;
  logic [1:0]                    corner;
  logic [vfm_pkg::VIDX_W-1:0]    vcount;
  logic                          out_valid;
  vfm_pkg::vtx_t                 out_data;

  logic                          adv;
  logic                          emit;
  logic [2:0]                    cur_face;
  logic [vfm_pkg::NUM_FACES-1:0] cur_onehot;
  logic [vfm_pkg::NUM_FACES-1:0] rest;
  logic                          is_last;
  logic [3:0]                    light;
  logic [2:0]                    r_cls;
  logic [2:0]                    g_cls;
  logic [2:0]                    b_cls;
  logic [2:0]                    cbits;
  vfm_pkg::vtx_t                 vtx_next;

  assign adv  = !out_valid || vtx.ready;
  assign pop  = !busy && !q_stat.empty;
  assign emit = busy && adv;

  // Pick the lowest face still to be emitted
  always_comb begin
    cur_face = vfm_pkg::FACE_PX;
    for (int i = vfm_pkg::NUM_FACES - 1; i >= 0; i--) begin
      if (remain[i]) begin
        cur_face = 3'(i);
      end
    end
    cur_onehot = '0;
    cur_onehot[cur_face] = 1'b1;
    rest    = remain & ~cur_onehot;
    is_last = (corner == 2'd3) && (rest == '0);
  end

  // Build the vertex for the current face and corner
  always_comb begin
    light = job.lights[cur_face];
    if (job.water) begin
      r_cls = vfm_pkg::BASE_50;
      g_cls = vfm_pkg::BASE_100;
      b_cls = vfm_pkg::BASE_255;
    end else begin
      r_cls = vfm_pkg::grey_class(cur_face);
      g_cls = r_cls;
      b_cls = r_cls;
    end
    cbits = vfm_pkg::CORNER_TBL[cur_face][corner];
    vtx_next.vert_idx = vcount;
    vtx_next.pos_x  = {1'b0, job.bx} + vfm_pkg::PXZ_W'(cbits[2]);
    vtx_next.pos_y  = {1'b0, job.by} + vfm_pkg::PY_W'(cbits[1]);
    vtx_next.pos_z  = {1'b0, job.bz} + vfm_pkg::PXZ_W'(cbits[0]);
    vtx_next.face   = cur_face;
    vtx_next.corner = corner;
    vtx_next.red    = vfm_pkg::SCALE_TBL[r_cls][light];
    vtx_next.green  = vfm_pkg::SCALE_TBL[g_cls][light];
    vtx_next.blue   = vfm_pkg::SCALE_TBL[b_cls][light];
    vtx_next.alpha  = job.water ? vfm_pkg::ALPHA_WATER : vfm_pkg::ALPHA_SOLID;
    vtx_next.last   = is_last;
  end

  // Load jobs, step through corners and faces, count vertices
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      remain <= '0;
      corner <= 2'd0;
      vcount <= '0;
    end else if (pop) begin
      job    <= head;
      remain <= head.keep;
      busy   <= |head.keep;
      corner <= 2'd0;
      if (head.first) begin
        vcount <= '0;
      end
    end else if (emit) begin
      vcount <= vcount + 1'b1;
      corner <= corner + 1'b1;
      if (corner == 2'd3) begin
        remain <= rest;
      end
      if (is_last) begin
        busy <= 1'b0;
      end
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (vtx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= vtx_next;
    end
  end

  assign vtx.valid = out_valid;
  assign vtx.data  = out_data;

  // A busy back end always has a face left to emit
  a_busy_has_face: assert property (@(posedge clk) disable iff (rst)
    busy |-> (remain != '0))
    else $error("back end busy with no face left");

  // The block's final vertex frees the back end
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (emit && is_last) |=> !busy)
    else $error("back end still busy after final vertex");

  // Corners start at zero for every face walk
  a_idle_corner: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (corner == 2'd0))
    else $error("corner counter not at zero while idle");

endmodule

`default_nettype wire

// ===== hw/rtl/voxel_face_culling_mesher.sv =====
// Top level of the voxel face-culling mesher: front, job queue and vertex back end.
//
// Usage:
//   blk carries one block per request: its type, position and the types and
//   light levels of its six neighbours. vtx carries one vertex per request,
//   four per visible face, faces in order +x,-x,+y,-y,+z,-z; last marks the
//   final vertex of a block. Air, filtered-out and fully hidden blocks give
//   no vertices. cfg_write/cfg_index/cfg_data write the five registers
//   (air, water, glass codes, type filter, face selection) while idle.
//   A taken block passes through the queue, then the load into the back end,
//   then the output register before its first vertex shows.
//   The back end emits one vertex per cycle while the receiver takes them, and
//   loads each block from the queue before its vertices. The two-entry queue
//   lets the front take new blocks while the back end is still emitting.
//   Reset clears the queue, the vertex counter and the registers to their
//   defaults. When the receiver stalls, the output register holds its vertex,
//   the back end waits, and blk.ready drops once the queue fills.
`default_nettype none

module voxel_face_culling_mesher (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [vfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vfm_pkg::CFG_DATA_W-1:0] cfg_data,
  vfm_chan_if.sink                            blk,
  vfm_chan_if.source                          vtx
);

  vfm_pkg::q_stat_t q_stat;
  vfm_pkg::job_t    push_job;
  vfm_pkg::job_t    head;
  logic             push;
  logic             pop;

  vfm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blk       (blk),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  vfm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  vfm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .vtx    (vtx)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench of the voxel face-culling mesher: directed table, then random blocks.
`default_nettype none

module testbench;

  localparam int HOLD_CYC  = 60;    // settle time for a full queue of two blocks
  localparam int STALL_MAX = 1000;  // cycles with no request moving before giving up
  localparam int RAND_PER_PHASE = 49;
  localparam int NUM_PHASES = 7;

  // Corner offsets of each face: bit 2 x, bit 1 y, bit 0 z
  localparam logic [2:0] QUAD_OFS [6][4] = '{
    '{3'd5, 3'd4, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd3, 3'd2},
    '{3'd3, 3'd7, 3'd6, 3'd2},
    '{3'd0, 3'd4, 3'd5, 3'd1},
    '{3'd1, 3'd5, 3'd7, 3'd3},
    '{3'd4, 3'd0, 3'd2, 3'd6}
  };

  typedef enum {ROW_BLK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    vfm_pkg::blk_t     blk;
    bit                typed;
    int                typed_cnt;
    vfm_pkg::vtx_t     typed_vtx;
    vfm_pkg::reg_idx_t ridx;
    logic [8:0]        rdat;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [vfm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vfm_pkg::CFG_DATA_W-1:0] cfg_data;

  vfm_chan_if #(.T(vfm_pkg::blk_t)) blk_ch ();
  vfm_chan_if #(.T(vfm_pkg::vtx_t)) vtx_ch ();

  voxel_face_culling_mesher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blk       (blk_ch),
    .vtx       (vtx_ch)
  );

  always #10 clk = ~clk;

  // Shadow registers and vertex counter of the mesher
  logic [7:0]  air_c, water_c, glass_c;
  logic [8:0]  filt_c;
  vfm_pkg::face_sel_t fsel_c;
  logic [vfm_pkg::VIDX_W-1:0] vcount;
  vfm_pkg::vtx_t vert_exp [$];
  int          errors = 0;

  // Tag of the block request currently on the channel
  logic          cur_typed;
  int            cur_typed_cnt;
  vfm_pkg::vtx_t cur_typed_vtx;

  // Values last written, used to shape the random blocks
  logic [7:0]  ph_air, ph_water, ph_glass;
  logic [8:0]  ph_filt;
  bit          calm = 1'b0;

  stim_row_t   plan [$];

  function automatic logic [7:0] dim(int unsigned c, logic [3:0] l);
    return 8'((c * (15 + 9 * l)) / 150);
  endfunction

  function automatic bit face_on(int f);
    case (fsel_c)
      vfm_pkg::FS_TOP:    return f == vfm_pkg::FACE_PY;
      vfm_pkg::FS_BOTTOM: return f == vfm_pkg::FACE_NY;
      vfm_pkg::FS_SIDES:  return f != vfm_pkg::FACE_PY && f != vfm_pkg::FACE_NY;
      default:            return 1'b1;
    endcase
  endfunction

  // Append the vertices that one block yields to the expected list
  task automatic mesh_block(input vfm_pkg::blk_t b);
    logic [7:0] nt;
    logic [3:0] nl;
    logic [2:0] ofs;
    bit         wet;
    int unsigned base;
    int         n0;
    vfm_pkg::vtx_t v;
    n0 = vert_exp.size();
    if (b.first_of_chunk) vcount = '0;
    if (b.block_type == air_c) return;
    if (!filt_c[8] && {1'b0, b.block_type} != filt_c) return;
    wet = (b.block_type == water_c);
    for (int f = 0; f < vfm_pkg::NUM_FACES; f++) begin
      nt = b.neighbor_types[8*f +: 8];
      nl = b.neighbor_lights[4*f +: 4];
      if (!face_on(f)) continue;
      if (nt != air_c && nt != water_c && nt != glass_c) continue;
      if (wet && nt == water_c) continue;
      case (f)
        vfm_pkg::FACE_PX, vfm_pkg::FACE_NX: base = 200;
        vfm_pkg::FACE_PY:                   base = 255;
        vfm_pkg::FACE_NY:                   base = 100;
        default:                            base = 170;
      endcase
      for (int k = 0; k < 4; k++) begin
        ofs = QUAD_OFS[f][k];
        v.vert_idx = vcount;
        v.pos_x  = vfm_pkg::PXZ_W'(b.block_x) + vfm_pkg::PXZ_W'(ofs[2]);
        v.pos_y  = vfm_pkg::PY_W'(b.block_y) + vfm_pkg::PY_W'(ofs[1]);
        v.pos_z  = vfm_pkg::PXZ_W'(b.block_z) + vfm_pkg::PXZ_W'(ofs[0]);
        v.face   = 3'(f);
        v.corner = 2'(k);
        v.red    = wet ? dim(50, nl)  : dim(base, nl);
        v.green  = wet ? dim(100, nl) : dim(base, nl);
        v.blue   = wet ? dim(255, nl) : dim(base, nl);
        v.alpha  = wet ? vfm_pkg::ALPHA_WATER : vfm_pkg::ALPHA_SOLID;
        v.last   = 1'b0;
        vert_exp.insert(vert_exp.size(), v);
        vcount = vcount + 1'b1;
      end
    end
    if (vert_exp.size() > n0) vert_exp[vert_exp.size()-1].last = 1'b1;
  endtask

  task automatic note(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: vertex %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Track register writes, predict accepted blocks, check accepted vertices
  always @(posedge clk) begin : monitor
    int   n0;
    vfm_pkg::vtx_t want;
    vfm_pkg::vtx_t got;
    if (rst) begin
      air_c = 8'd0; water_c = 8'd1; glass_c = 8'd2; filt_c = 9'h1FF;
      fsel_c = vfm_pkg::FS_ALL;
      vcount = '0;
      vert_exp.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          vfm_pkg::REG_AIR:      air_c = cfg_data[7:0];
          vfm_pkg::REG_WATER:    water_c = cfg_data[7:0];
          vfm_pkg::REG_GLASS:    glass_c = cfg_data[7:0];
          vfm_pkg::REG_FILTER:   filt_c = cfg_data[8:0];
          vfm_pkg::REG_FACE_SEL: fsel_c = vfm_pkg::face_sel_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (blk_ch.valid && blk_ch.ready) begin
        n0 = vert_exp.size();
        mesh_block(blk_ch.data);
        if (cur_typed) begin
          if (cur_typed_cnt == 0) begin
            while (vert_exp.size() > n0) vert_exp.pop_back();
          end else if (vert_exp.size() > n0) begin
            vert_exp[n0] = cur_typed_vtx;
          end
        end
      end
      if (vtx_ch.valid && vtx_ch.ready) begin
        got = vtx_ch.data;
        if (vert_exp.size() == 0) begin
          $display("%0t: unexpected vertex, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = vert_exp.pop_front();
          note("vert_idx", want.vert_idx, got.vert_idx);
          note("pos_x", want.pos_x, got.pos_x);
          note("pos_y", want.pos_y, got.pos_y);
          note("pos_z", want.pos_z, got.pos_z);
          note("face", want.face, got.face);
          note("corner", want.corner, got.corner);
          note("red", want.red, got.red);
          note("green", want.green, got.green);
          note("blue", want.blue, got.blue);
          note("alpha", want.alpha, got.alpha);
          note("last", want.last, got.last);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst) begin
      quiet = 0;
    end else if ((blk_ch.valid && blk_ch.ready) || (vtx_ch.valid && vtx_ch.ready) || cfg_write)
    begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stall the vertex receiver in random bursts, never during the calm phase
  initial begin : receiver
    int stall;
    stall = 0;
    vtx_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        vtx_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        vtx_ch.ready <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 9) == 0) begin
        vtx_ch.ready <= 1'b0;
        stall = $urandom_range(1, 7) - 1;
      end else begin
        vtx_ch.ready <= 1'b1;
      end
    end
  end

  function automatic vfm_pkg::blk_t mk_blk(bit first, logic [7:0] bt, logic [3:0] x,
                                           logic [7:0] y, logic [3:0] z, logic [47:0] nt,
                                           logic [23:0] nl);
    vfm_pkg::blk_t b;
    b.first_of_chunk = first;
    b.block_type = bt;
    b.block_x = x;
    b.block_y = y;
    b.block_z = z;
    b.neighbor_types = nt;
    b.neighbor_lights = nl;
    return b;
  endfunction

  function automatic vfm_pkg::vtx_t mk_vtx(int unsigned idx, int unsigned x, int unsigned y,
                                           int unsigned z, logic [2:0] f, logic [7:0] r,
                                           logic [7:0] g, logic [7:0] bl, logic [7:0] a);
    vfm_pkg::vtx_t v;
    v.vert_idx = vfm_pkg::VIDX_W'(idx);
    v.pos_x = vfm_pkg::PXZ_W'(x);
    v.pos_y = vfm_pkg::PY_W'(y);
    v.pos_z = vfm_pkg::PXZ_W'(z);
    v.face = f;
    v.corner = 2'd0;
    v.red = r;
    v.green = g;
    v.blue = bl;
    v.alpha = a;
    v.last = 1'b0;
    return v;
  endfunction

  task automatic add_blk(input vfm_pkg::blk_t b, input bit typed = 1'b0, input int cnt = 0,
                         input vfm_pkg::vtx_t v = '0);
    stim_row_t r;
    r.kind = ROW_BLK;
    r.blk = b;
    r.typed = typed;
    r.typed_cnt = cnt;
    r.typed_vtx = v;
    r.ridx = vfm_pkg::REG_AIR;
    r.rdat = '0;
    plan.insert(plan.size(), r);
  endtask

  task automatic add_cfg(input vfm_pkg::reg_idx_t idx, input logic [8:0] dat);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.blk = '0;
    r.typed = 1'b0;
    r.typed_cnt = 0;
    r.typed_vtx = '0;
    r.ridx = idx;
    r.rdat = dat;
    plan.insert(plan.size(), r);
  endtask

  // Let every pending vertex come out, then let the mesher settle
  task automatic drain();
    @(posedge clk);
    while (vert_exp.size() != 0) @(posedge clk);
    repeat (HOLD_CYC) @(posedge clk);
  endtask

  task automatic cfg_set(input vfm_pkg::reg_idx_t idx, input logic [8:0] dat);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dat;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input logic [7:0] a, input logic [7:0] w, input logic [7:0] g,
                           input logic [8:0] f, input vfm_pkg::face_sel_t s);
    drain();
    cfg_set(vfm_pkg::REG_AIR, {1'b0, a});
    cfg_set(vfm_pkg::REG_WATER, {1'b0, w});
    cfg_set(vfm_pkg::REG_GLASS, {1'b0, g});
    cfg_set(vfm_pkg::REG_FILTER, f);
    cfg_set(vfm_pkg::REG_FACE_SEL, {7'd0, s});
    ph_air = a; ph_water = w; ph_glass = g; ph_filt = f;
  endtask

  // Offer one block request, with an optional gap ahead of it, and wait until it is taken
  task automatic send(input vfm_pkg::blk_t b, input bit typed, input int cnt,
                      input vfm_pkg::vtx_t v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      blk_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    blk_ch.valid  <= 1'b1;
    blk_ch.data   <= b;
    cur_typed     <= typed;
    cur_typed_cnt <= cnt;
    cur_typed_vtx <= v;
    @(posedge clk);
    while (!blk_ch.ready) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_nb();
    case ($urandom_range(0, 9))
      0, 1:    return ph_air;
      2:       return ph_water;
      3:       return ph_glass;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly meshable blocks with random content, the rest air or arbitrary codes
  function automatic vfm_pkg::blk_t rand_blk();
    vfm_pkg::blk_t b;
    logic [7:0] bt;
    if ($urandom_range(0, 6) != 0) begin
      if (!ph_filt[8] && $urandom_range(0, 3) != 0) bt = ph_filt[7:0];
      else if ($urandom_range(0, 3) == 0) bt = ph_water;
      else if ($urandom_range(0, 7) == 0) bt = ph_glass;
      else bt = 8'($urandom_range(0, 255));
    end else begin
      bt = ($urandom_range(0, 1) == 0) ? ph_air : 8'($urandom_range(0, 255));
    end
    b.first_of_chunk  = ($urandom_range(0, 15) == 0);
    b.block_type      = bt;
    b.block_x         = 4'($urandom_range(0, 15));
    b.block_y         = 8'($urandom_range(0, 255));
    b.block_z         = 4'($urandom_range(0, 15));
    for (int f = 0; f < vfm_pkg::NUM_FACES; f++) b.neighbor_types[8*f +: 8] = pick_nb();
    b.neighbor_lights = 24'($urandom);
    return b;
  endfunction

  initial begin : stimulus
    vfm_pkg::blk_t b;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    blk_ch.valid <= 1'b0;
    blk_ch.data <= '0;
    cur_typed <= 1'b0;
    cur_typed_cnt <= 0;
    cur_typed_vtx <= '0;
    ph_air = 8'd0; ph_water = 8'd1; ph_glass = 8'd2; ph_filt = 9'h1FF;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows under the reset settings
    add_blk(mk_blk(0, 8'd0, 4'd5, 8'd5, 4'd5, 48'h0, 24'h0), 1, 0);
    add_blk(mk_blk(0, 8'd5, 4'd0, 8'd0, 4'd0, 48'h050505050500, 24'h00000F), 1, 4,
            mk_vtx(0, 1, 0, 1, vfm_pkg::FACE_PX, 8'd200, 8'd200, 8'd200,
                   vfm_pkg::ALPHA_SOLID));
    add_blk(mk_blk(0, 8'd255, 4'd15, 8'd255, 4'd15, 48'hFFFFFF00FFFF, 24'h0), 1, 4,
            mk_vtx(4, 15, 256, 16, vfm_pkg::FACE_PY, 8'd25, 8'd25, 8'd25,
                   vfm_pkg::ALPHA_SOLID));
    add_blk(mk_blk(1, 8'd1, 4'd3, 8'd7, 4'd9, 48'h010102010101, 24'h00F000), 1, 4,
            mk_vtx(0, 3, 7, 9, vfm_pkg::FACE_NY, 8'd50, 8'd100, 8'd255,
                   vfm_pkg::ALPHA_WATER));
    // water against water on every side
    add_blk(mk_blk(0, 8'd1, 4'd8, 8'd8, 4'd8, 48'h010101010101, 24'hFFFFFF), 1, 0);
    // hidden block still restarts the count
    add_blk(mk_blk(1, 8'd9, 4'd2, 8'd2, 4'd2, 48'h090909090909, 24'h123456), 1, 0);
    add_blk(mk_blk(0, 8'd200, 4'd15, 8'd255, 4'd15, 48'h0, 24'hFFFFFF), 1, 24,
            mk_vtx(0, 16, 255, 16, vfm_pkg::FACE_PX, 8'd200, 8'd200, 8'd200,
                   vfm_pkg::ALPHA_SOLID));
    add_blk(mk_blk(0, 8'd1, 4'd6, 8'd100, 4'd1, 48'h020001020001, 24'h123456));
    add_blk(mk_blk(0, 8'h80, 4'd0, 8'd0, 4'd0, 48'h0, 24'hA5C3F0));
    add_blk(mk_blk(0, 8'hAA, 4'd5, 8'd128, 4'd10, 48'h000102555501, 24'h9E7D4B));
    // filter on one type
    add_cfg(vfm_pkg::REG_FILTER, 9'd7);
    add_blk(mk_blk(0, 8'd7, 4'd0, 8'd0, 4'd0, 48'h070002000107, 24'h5A5A5A));
    add_blk(mk_blk(0, 8'd8, 4'd1, 8'd1, 4'd1, 48'h0, 24'h0), 1, 0);
    // each face selection
    add_cfg(vfm_pkg::REG_FACE_SEL, {7'd0, vfm_pkg::FS_TOP});
    add_blk(mk_blk(0, 8'd7, 4'd9, 8'd30, 4'd4, 48'h0, 24'h0F0F0F));
    add_cfg(vfm_pkg::REG_FACE_SEL, {7'd0, vfm_pkg::FS_BOTTOM});
    add_blk(mk_blk(0, 8'd7, 4'd9, 8'd30, 4'd4, 48'h0, 24'hF0F0F0));
    add_cfg(vfm_pkg::REG_FACE_SEL, {7'd0, vfm_pkg::FS_SIDES});
    add_blk(mk_blk(1, 8'd7, 4'd9, 8'd30, 4'd4, 48'h0, 24'h369CF2));
    // filter naming the air code
    add_cfg(vfm_pkg::REG_FACE_SEL, {7'd0, vfm_pkg::FS_ALL});
    add_cfg(vfm_pkg::REG_FILTER, 9'd0);
    add_blk(mk_blk(0, 8'd0, 4'd3, 8'd3, 4'd3, 48'h0, 24'hFFFFFF), 1, 0);
    add_blk(mk_blk(0, 8'd5, 4'd3, 8'd3, 4'd3, 48'h0, 24'hFFFFFF), 1, 0);
    // air and water sharing a code
    add_cfg(vfm_pkg::REG_FILTER, 9'h1FF);
    add_cfg(vfm_pkg::REG_WATER, 9'd0);
    add_blk(mk_blk(0, 8'd0, 4'd4, 8'd4, 4'd4, 48'h0, 24'h0), 1, 0);
    add_blk(mk_blk(0, 8'd5, 4'd4, 8'd4, 4'd4, 48'h000000000000, 24'h777777));
    // water and glass sharing a code
    add_cfg(vfm_pkg::REG_WATER, 9'd3);
    add_cfg(vfm_pkg::REG_GLASS, 9'd3);
    add_blk(mk_blk(0, 8'd3, 4'd11, 8'd200, 4'd12, 48'h030303000000, 24'hE1D2C3));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        blk_ch.valid <= 1'b0;
        drain();
        cfg_set(plan[i].ridx, plan[i].rdat);
      end else begin
        send(plan[i].blk, plan[i].typed, plan[i].typed_cnt, plan[i].typed_vtx);
      end
    end

    // Random phases, each under its own settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      blk_ch.valid <= 1'b0;
      case (p)
        0: apply_cfg(8'd0, 8'd1, 8'd2, 9'h1FF, vfm_pkg::FS_ALL);
        1: apply_cfg(8'd255, 8'd0, 8'd128, 9'h1FF, vfm_pkg::FS_TOP);
        2: apply_cfg(8'd7, 8'd7, 8'd9, 9'd9, vfm_pkg::FS_BOTTOM);
        3: apply_cfg(8'd3, 8'd200, 8'd200, 9'd200, vfm_pkg::FS_SIDES);
        4: apply_cfg(8'd0, 8'd255, 8'd255, 9'd255, vfm_pkg::FS_ALL);
        5: apply_cfg(8'd170, 8'd85, 8'd0, 9'h100, vfm_pkg::FS_ALL);
        default: begin
          calm = 1'b1;
          apply_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)),
                    ($urandom_range(0, 1) == 0) ? 9'h1FF : 9'($urandom_range(0, 255)),
                    vfm_pkg::face_sel_t'($urandom_range(0, 3)));
        end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // hold off once, in the middle of phase 2, until the mesher has caught up
        if (p == 2 && n == RAND_PER_PHASE / 2) begin
          blk_ch.valid <= 1'b0;
          @(posedge clk);
          while (vert_exp.size() != 0) @(posedge clk);
        end
        b = rand_blk();
        send(b, 1'b0, 0, '0);
      end
    end

    blk_ch.valid <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/vfm_pkg.sv
hw/rtl/vfm_chan_if.sv
hw/rtl/vfm_front.sv
hw/rtl/vfm_queue.sv
hw/rtl/vfm_back.sv
hw/rtl/voxel_face_culling_mesher.sv
test/testbench.sv
